/* hw/rtl/dna_pkg.sv */
`timescale 1ns / 1ps

package dna_pkg;

    localparam int DATA_W        = 32;
    localparam int PROD_W        = 64;
    localparam int SUM_W         = PROD_W + 1;
    localparam int QUO_BITS      = DATA_W;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    // one divider lane: partial remainder, dividend bits still to shift in, quotient so far
    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [DATA_W-1:0] low;
        logic [DATA_W-1:0] quo;
        logic [PROD_W-1:0] dvs;
        logic              neg;
        logic              ovf;
    } t_lane;

    typedef struct packed {
        logic [1:0]        op;
        logic              div0;
        logic [DATA_W-1:0] byp_value;
        logic [DATA_W-1:0] byp_deriv;
        logic [1:0]        byp_status;
        t_lane             lv;
        t_lane             ld;
    } t_div_word;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } t_sat;

    function automatic t_sat sat32(input logic signed [SUM_W-1:0] x);
        t_sat s;
        s.ovf = (x[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){x[DATA_W-1]}});
        s.val = s.ovf ? (x[SUM_W-1] ? SAT_MIN : SAT_MAX) : x[DATA_W-1:0];
        return s;
    endfunction

endpackage

/* hw/rtl/dna_front.sv */
`timescale 1ns / 1ps

module dna_front #(
    parameter int FRAC_BITS = dna_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_func,
    input  logic signed [31:0]       i_a_value,
    input  logic signed [31:0]       i_a_deriv,
    input  logic signed [31:0]       i_b_value,
    input  logic signed [31:0]       i_b_deriv,
    output logic                     o_valid,
    input  logic                     i_ready,
    output dna_pkg::t_div_word       o_word
);

    // stage 1: products
    logic                     r1_vld;
    logic [1:0]               r1_op;
    logic signed [31:0]       r1_av, r1_ad, r1_bv, r1_bd;
    logic signed [63:0]       r1_p_vv, r1_p_adbv, r1_p_avbd, r1_p_bb;
    logic signed [63:0]       n1_p_vv, n1_p_adbv, n1_p_avbd, n1_p_bb;

    // stage 2: wide sums
    logic                     r2_vld;
    logic [1:0]               r2_op;
    logic signed [31:0]       r2_av, r2_bv;
    logic [63:0]              r2_bb;
    logic signed [64:0]       r2_sum_v, r2_sum_d;
    logic signed [64:0]       n2_sum_v, n2_sum_d;

    // stage 3: rescale, saturate, divider setup
    logic                     r3_vld;
    dna_pkg::t_div_word       r3_word;
    dna_pkg::t_div_word       n3_word;

    logic rdy1, rdy2, rdy3;

    assign rdy3    = !r3_vld || i_ready;
    assign rdy2    = !r2_vld || rdy3;
    assign rdy1    = !r1_vld || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r3_vld;
    assign o_word  = r3_word;

    assign n1_p_vv   = 64'(i_a_value) * 64'(i_b_value);
    assign n1_p_adbv = 64'(i_a_deriv) * 64'(i_b_value);
    assign n1_p_avbd = 64'(i_a_value) * 64'(i_b_deriv);
    assign n1_p_bb   = 64'(i_b_value) * 64'(i_b_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (rdy1) begin
            r1_vld <= i_valid;
        end
        if (rdy1 && i_valid) begin
            r1_op     <= i_func;
            r1_av     <= i_a_value;
            r1_ad     <= i_a_deriv;
            r1_bv     <= i_b_value;
            r1_bd     <= i_b_deriv;
            r1_p_vv   <= n1_p_vv;
            r1_p_adbv <= n1_p_adbv;
            r1_p_avbd <= n1_p_avbd;
            r1_p_bb   <= n1_p_bb;
        end
    end

    always_comb begin
        case (r1_op)
            dna_pkg::OP_ADD: begin
                n2_sum_v = 65'(r1_av) + 65'(r1_bv);
                n2_sum_d = 65'(r1_ad) + 65'(r1_bd);
            end
            dna_pkg::OP_SUB: begin
                n2_sum_v = 65'(r1_av) - 65'(r1_bv);
                n2_sum_d = 65'(r1_ad) - 65'(r1_bd);
            end
            dna_pkg::OP_MUL: begin
                n2_sum_v = 65'(r1_p_vv);
                n2_sum_d = 65'(r1_p_adbv) + 65'(r1_p_avbd);
            end
            default: begin
                n2_sum_v = 65'(r1_p_vv);
                n2_sum_d = 65'(r1_p_adbv) - 65'(r1_p_avbd);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (rdy2) begin
            r2_vld <= r1_vld;
        end
        if (rdy2 && r1_vld) begin
            r2_op    <= r1_op;
            r2_av    <= r1_av;
            r2_bv    <= r1_bv;
            r2_bb    <= r1_p_bb;
            r2_sum_v <= n2_sum_v;
            r2_sum_d <= n2_sum_d;
        end
    end

    logic signed [64:0] sh_v, sh_d;
    dna_pkg::t_sat      sat_v, sat_d;
    logic [31:0]        mag_av, mag_bv;
    logic [63:0]        num_v;
    logic [63:0]        mag_n;
    logic [64:0]        neg_n;
    logic [127:0]       num_d;

    always_comb begin
        sh_v  = (r2_op == dna_pkg::OP_MUL) ? (r2_sum_v >>> FRAC_BITS) : r2_sum_v;
        sh_d  = (r2_op == dna_pkg::OP_MUL) ? (r2_sum_d >>> FRAC_BITS) : r2_sum_d;
        sat_v = dna_pkg::sat32(sh_v);
        sat_d = dna_pkg::sat32(sh_d);

        mag_av = r2_av[31] ? 32'(-r2_av) : 32'(r2_av);
        mag_bv = r2_bv[31] ? 32'(-r2_bv) : 32'(r2_bv);
        num_v  = {32'b0, mag_av} << FRAC_BITS;
        neg_n  = -r2_sum_d;
        mag_n  = r2_sum_d[64] ? neg_n[63:0] : r2_sum_d[63:0];
        num_d  = {64'b0, mag_n} << FRAC_BITS;

        n3_word.op         = r2_op;
        n3_word.div0       = (r2_bv == 32'sd0);
        n3_word.byp_value  = sat_v.val;
        n3_word.byp_deriv  = sat_d.val;
        n3_word.byp_status = (sat_v.ovf || sat_d.ovf) ? dna_pkg::ST_OVF : dna_pkg::ST_OK;

        n3_word.lv.rem = {32'b0, num_v[63:32]};
        n3_word.lv.low = num_v[31:0];
        n3_word.lv.quo = '0;
        n3_word.lv.dvs = {32'b0, mag_bv};
        n3_word.lv.neg = r2_av[31] ^ r2_bv[31];
        n3_word.lv.ovf = 1'b0;

        n3_word.ld.rem = num_d[95:32];
        n3_word.ld.low = num_d[31:0];
        n3_word.ld.quo = '0;
        n3_word.ld.dvs = r2_bb;
        n3_word.ld.neg = r2_sum_d[64];
        n3_word.ld.ovf = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (rdy3) begin
            r3_vld <= r2_vld;
        end
        if (rdy3 && r2_vld) begin
            r3_word <= n3_word;
        end
    end

endmodule

/* hw/rtl/dna_div.sv */
`timescale 1ns / 1ps

module dna_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dna_pkg::t_div_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output dna_pkg::t_div_word  o_word
);

    localparam int NST = dna_pkg::QUO_BITS;

    // one restoring step; the first step also flags a quotient too wide for 32 bits
    function automatic dna_pkg::t_lane div_step(input dna_pkg::t_lane l, input logic first);
        dna_pkg::t_lane o;
        logic [65:0]    trial;
        trial = {1'b0, l.rem, l.low[31]} - {2'b0, l.dvs};
        o     = l;
        o.ovf = l.ovf || (first && (l.rem >= l.dvs));
        o.low = {l.low[30:0], 1'b0};
        o.quo = {l.quo[30:0], !trial[65]};
        o.rem = trial[65] ? {l.rem[62:0], l.low[31]} : trial[63:0];
        return o;
    endfunction

    logic               r_vld  [NST];
    dna_pkg::t_div_word r_word [NST];
    logic               stg_rdy [NST];

    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_stage
            logic               up_vld;
            dna_pkg::t_div_word up_word;
            dna_pkg::t_div_word n_word;
            logic               dn_rdy;

            if (k == 0) begin : g_first
                assign up_vld  = i_valid;
                assign up_word = i_word;
            end else begin : g_next
                assign up_vld  = r_vld[k-1];
                assign up_word = r_word[k-1];
            end

            if (k == NST - 1) begin : g_last
                assign dn_rdy = i_ready;
            end else begin : g_mid
                assign dn_rdy = stg_rdy[k+1];
            end

            assign stg_rdy[k] = !r_vld[k] || dn_rdy;

            always_comb begin
                n_word    = up_word;
                n_word.lv = div_step(up_word.lv, k == 0);
                n_word.ld = div_step(up_word.ld, k == 0);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (stg_rdy[k]) begin
                    r_vld[k] <= up_vld;
                end
                if (stg_rdy[k] && up_vld) begin
                    r_word[k] <= n_word;
                end
            end
        end
    endgenerate

    assign o_ready = stg_rdy[0];
    assign o_valid = r_vld[NST-1];
    assign o_word  = r_word[NST-1];

endmodule

/* hw/rtl/dna_back.sv */
`timescale 1ns / 1ps

module dna_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dna_pkg::t_div_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_res_value,
    output logic [31:0]         o_res_deriv,
    output logic [1:0]          o_status
);

    function automatic dna_pkg::t_sat lane_out(input dna_pkg::t_lane l);
        dna_pkg::t_sat s;
        if (l.neg) begin
            s.ovf = l.ovf || (l.quo > dna_pkg::SAT_MIN);
            s.val = s.ovf ? dna_pkg::SAT_MIN : 32'(-l.quo);
        end else begin
            s.ovf = l.ovf || l.quo[31];
            s.val = s.ovf ? dna_pkg::SAT_MAX : l.quo;
        end
        return s;
    endfunction

    logic          r_vld;
    logic [31:0]   r_value, r_deriv;
    logic [1:0]    r_status;
    logic [31:0]   n_value, n_deriv;
    logic [1:0]    n_status;
    dna_pkg::t_sat q_v, q_d;
    logic          rdy;

    assign rdy     = !r_vld || i_ready;
    assign o_ready = rdy;

    always_comb begin
        q_v = lane_out(i_word.lv);
        q_d = lane_out(i_word.ld);
        if (i_word.op != dna_pkg::OP_DIV) begin
            n_value  = i_word.byp_value;
            n_deriv  = i_word.byp_deriv;
            n_status = i_word.byp_status;
        end else if (i_word.div0) begin
            n_value  = '0;
            n_deriv  = '0;
            n_status = dna_pkg::ST_DIV0;
        end else begin
            n_value  = q_v.val;
            n_deriv  = q_d.val;
            n_status = (q_v.ovf || q_d.ovf) ? dna_pkg::ST_OVF : dna_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (rdy) begin
            r_vld <= i_valid;
        end
        if (rdy && i_valid) begin
            r_value  <= n_value;
            r_deriv  <= n_deriv;
            r_status <= n_status;
        end
    end

    assign o_valid     = r_vld;
    assign o_res_value = r_value;
    assign o_res_deriv = r_deriv;
    assign o_status    = r_status;

endmodule

/* hw/rtl/dual_number_alu_unit.sv */
`timescale 1ns / 1ps
// an accepted word passes the front stages, the divider stages and the output register
// throughput: one word per cycle barring stalls, from the bit-per-stage divider pipeline
// a stall at the output backs up only full stages; bubbles are squeezed out meanwhile
// reset (synchronous, active low) clears every stage valid bit; data regs are not reset

module dual_number_alu_unit #(
    parameter int FRAC_BITS = dna_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // operand side
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_a_value,
    input  logic signed [31:0] i_a_deriv,
    input  logic signed [31:0] i_b_value,
    input  logic signed [31:0] i_b_deriv,
    // result side
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_res_value,
    output logic signed [31:0] o_res_deriv,
    output logic [1:0]         o_status
);

    // front: products (stage 1), wide sums (stage 2), rescale/saturate and
    // divider setup (stage 3); add/sub/mul results ride along as bypass data
    logic               fr_valid, fr_ready;
    dna_pkg::t_div_word fr_word;

    // divider: two lanes (value and derivative quotient), one quotient bit per stage
    logic               dv_valid, dv_ready;
    dna_pkg::t_div_word dv_word;

    logic [31:0] bk_value, bk_deriv;

    dna_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_func    (i_func),
        .i_a_value (i_a_value),
        .i_a_deriv (i_a_deriv),
        .i_b_value (i_b_value),
        .i_b_deriv (i_b_deriv),
        .o_valid   (fr_valid),
        .i_ready   (fr_ready),
        .o_word    (fr_word)
    );

    dna_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_word  (fr_word),
        .o_valid (dv_valid),
        .i_ready (dv_ready),
        .o_word  (dv_word)
    );

    // back: sign, saturation and zero-divisor handling, then the output register
    dna_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (dv_valid),
        .o_ready     (dv_ready),
        .i_word      (dv_word),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res_value (bk_value),
        .o_res_deriv (bk_deriv),
        .o_status    (o_status)
    );

    assign o_res_value = bk_value;
    assign o_res_deriv = bk_deriv;

    // zero divisor always returns zero data
    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == dna_pkg::ST_DIV0) |-> (bk_value == '0) && (bk_deriv == '0))
        else $error("divide-by-zero result carries nonzero data");

    // an overflow status means at least one field sits at a rail
    a_ovf_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == dna_pkg::ST_OVF) |->
            (bk_value == dna_pkg::SAT_MAX) || (bk_value == dna_pkg::SAT_MIN) ||
            (bk_deriv == dna_pkg::SAT_MAX) || (bk_deriv == dna_pkg::SAT_MIN))
        else $error("overflow status without a saturated field");

    // an empty output register lets the whole ready chain open
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output register is empty");

endmodule

/* bench/tb_dual_number_alu_unit.sv */
`timescale 1ns / 1ps

module tb_dual_number_alu_unit;

    localparam int FRAC      = dna_pkg::FRAC_BITS_DEF;
    localparam int LATENCY   = 36;
    localparam int WD_LIMIT  = 5000;
    localparam int N_RANDOM  = 390;

    // one operand word as driven on the input side
    typedef struct {
        logic [1:0]         func;
        logic signed [31:0] a_value;
        logic signed [31:0] a_deriv;
        logic signed [31:0] b_value;
        logic signed [31:0] b_deriv;
    } t_operand;

    // one result word as seen on the output side
    typedef struct {
        logic signed [31:0] res_value;
        logic signed [31:0] res_deriv;
        logic [1:0]         status;
    } t_result;

    // expected results in order, and the check of each output word against the oldest
    class dual_scoreboard;
        t_result expected_q[$];
        int      errors;
        int      checked;
        int      n_ops[4];

        function automatic logic signed [31:0] clamp32(input logic signed [127:0] x,
                                                       inout bit ovf);
            if (x > 128'sh7FFF_FFFF) begin
                ovf = 1'b1;
                return 32'sh7FFF_FFFF;
            end
            if (x < -128'sh8000_0000) begin
                ovf = 1'b1;
                return 32'sh8000_0000;
            end
            return x[31:0];
        endfunction

        // sum, difference, product rule or quotient rule of two dual numbers
        function automatic t_result dual_arith(t_operand w);
            logic signed [127:0] av, ad, bv, bd, rv, rd, num, mag, den, q;
            bit      ovf;
            t_result r;
            av = 128'(w.a_value);
            ad = 128'(w.a_deriv);
            bv = 128'(w.b_value);
            bd = 128'(w.b_deriv);
            rv = 0;
            rd = 0;
            ovf = 1'b0;
            case (w.func)
                dna_pkg::OP_ADD: begin
                    rv = av + bv;
                    rd = ad + bd;
                end
                dna_pkg::OP_SUB: begin
                    rv = av - bv;
                    rd = ad - bd;
                end
                dna_pkg::OP_MUL: begin
                    // arithmetic shift floors toward minus infinity
                    rv = (av * bv) >>> FRAC;
                    rd = (ad * bv + av * bd) >>> FRAC;
                end
                default: begin
                    if (bv != 0) begin
                        // signed division truncates toward zero
                        rv = (av <<< FRAC) / bv;
                        num = ad * bv - av * bd;
                        mag = (num < 0) ? -num : num;
                        den = bv * bv;
                        q = (mag <<< FRAC) / den;
                        rd = (num < 0) ? -q : q;
                    end
                end
            endcase
            r.res_value = clamp32(rv, ovf);
            r.res_deriv = clamp32(rd, ovf);
            if (w.func == dna_pkg::OP_DIV && w.b_value == 0)
                r.status = dna_pkg::ST_DIV0;
            else
                r.status = ovf ? dna_pkg::ST_OVF : dna_pkg::ST_OK;
            return r;
        endfunction

        function void note_operands(t_operand w);
            n_ops[w.func]++;
            expected_q.push_back(dual_arith(w));
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected result word: value %h deriv %h status %0d",
                             $realtime, got.res_value, got.res_deriv, got.status);
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            if (got.res_value !== exp_r.res_value || got.res_deriv !== exp_r.res_deriv
                    || got.status !== exp_r.status) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] mismatch: value %h/%h deriv %h/%h status %0d/%0d (exp/got)",
                             $realtime, exp_r.res_value, got.res_value, exp_r.res_deriv,
                             got.res_deriv, exp_r.status, got.status);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_func;
    logic signed [31:0] i_a_value;
    logic signed [31:0] i_a_deriv;
    logic signed [31:0] i_b_value;
    logic signed [31:0] i_b_deriv;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_res_value;
    logic signed [31:0] o_res_deriv;
    logic [1:0]         o_status;

    dual_number_alu_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_a_value   (i_a_value),
        .i_a_deriv   (i_a_deriv),
        .i_b_value   (i_b_value),
        .i_b_deriv   (i_b_deriv),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res_value (o_res_value),
        .o_res_deriv (o_res_deriv),
        .o_status    (o_status)
    );

    dual_scoreboard sb;
    int send_idle_pct;      // chance per word that the sender inserts idle cycles
    int recv_idle_pct;      // chance per cycle that the receiver holds off ready
    int quiet_cycles;       // cycles with no word moving on either side
    bit bench_live;

    // 20 ns clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // receiver back-pressure, random per cycle
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: every accepted operand word is predicted, every result word is checked
    always @(posedge i_clk) begin
        t_operand w;
        t_result  r;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                w.func    = i_func;
                w.a_value = i_a_value;
                w.a_deriv = i_a_deriv;
                w.b_value = i_b_value;
                w.b_deriv = i_b_deriv;
                sb.note_operands(w);
            end
            if (o_valid && i_ready) begin
                r.res_value = o_res_value;
                r.res_deriv = o_res_deriv;
                r.status    = o_status;
                sb.check_result(r);
            end
        end
    end

    // watchdog: a hung handshake ends the run
    always @(posedge i_clk) begin
        if (!bench_live || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                         WD_LIMIT, sb.expected_q.size());
                $display("** dual_number_alu_unit: FAILED **");
                $finish;
            end
        end
    end

    // present one operand word and hold it until the block takes it
    task automatic send_operands(input logic [1:0] f, input logic [31:0] av,
                                 input logic [31:0] ad, input logic [31:0] bv,
                                 input logic [31:0] bd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= f;
        i_a_value <= av;
        i_a_deriv <= ad;
        i_b_value <= bv;
        i_b_deriv <= bd;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic go_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every expected result has come back, then let the pipe settle
    task automatic drain_results();
        go_quiet();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // operand value of mixed magnitude: full range, tiny, near one, or an extreme
    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0, 1:    return $urandom;
            2, 3:    return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
            4:       return {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
            5:       return ($urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000)
                            + 32'($urandom_range(255)) - 32'd128;
            6:       return {$urandom_range(1) ? 16'h0000 : 16'hFFFF, 16'($urandom)};
            default: begin
                case ($urandom_range(4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
        endcase
    endfunction

    task automatic random_words(input int n);
        logic [1:0]  f;
        logic [31:0] bv;
        for (int k = 0; k < n; k++) begin
            f = 2'($urandom_range(3));
            bv = pick_value();
            // a zero divisor now and then
            if (f == dna_pkg::OP_DIV && $urandom_range(9) == 0)
                bv = 32'h0;
            send_operands(f, pick_value(), pick_value(), bv, pick_value());
        end
    endtask

    initial begin
        sb = new();
        bench_live    = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_func    = dna_pkg::OP_ADD;
        i_a_value = '0;
        i_a_deriv = '0;
        i_b_value = '0;
        i_b_deriv = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        bench_live <= 1'b1;
        @(posedge i_clk);

        // directed words: extremes, every operation, saturation both ways, zero divisor
        send_operands(dna_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
        send_operands(dna_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_operands(dna_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_operands(dna_pkg::OP_ADD, 32'h0001_8000, 32'h0000_0000, 32'hFFFF_4000, 32'h0000_0000);
        send_operands(dna_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_operands(dna_pkg::OP_SUB, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_operands(dna_pkg::OP_SUB, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'h0000_0000);
        send_operands(dna_pkg::OP_MUL, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'h0000_0000);
        send_operands(dna_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_operands(dna_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_operands(dna_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
        send_operands(dna_pkg::OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
        send_operands(dna_pkg::OP_MUL, 32'hFFFF_8000, 32'h0000_8000, 32'h0000_0003, 32'hFFFF_FFFD);
        send_operands(dna_pkg::OP_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        send_operands(dna_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        send_operands(dna_pkg::OP_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        send_operands(dna_pkg::OP_DIV, 32'hFFFD_0000, 32'h0000_0000, 32'h0002_0000, 32'h0000_0000);
        send_operands(dna_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_operands(dna_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        send_operands(dna_pkg::OP_DIV, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_operands(dna_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_operands(dna_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0003, 32'h0000_0007);
        // sender waits for the pipe to empty before the random part
        drain_results();

        // receiver stalls more than sender idles, then the reverse, then no idling
        send_idle_pct = 16;
        recv_idle_pct = 59;
        random_words(N_RANDOM / 3);
        drain_results();
        send_idle_pct = 59;
        recv_idle_pct = 16;
        random_words(N_RANDOM / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_words(N_RANDOM - 2 * (N_RANDOM / 3));
        drain_results();

        $display("covered %0d add, %0d sub, %0d mul, %0d div words; %0d results checked",
                 sb.n_ops[dna_pkg::OP_ADD], sb.n_ops[dna_pkg::OP_SUB],
                 sb.n_ops[dna_pkg::OP_MUL], sb.n_ops[dna_pkg::OP_DIV], sb.checked);
        $display("mismatches: %0d", sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("** dual_number_alu_unit: PASSED **");
        else
            $display("** dual_number_alu_unit: FAILED **");
        $finish;
    end

endmodule
